>>> rtl/core/sfd_pkg.sv
package sfd_pkg;

    // header length default, range 4 to 16
    localparam int HEADER_BYTES_DEF = 8;

    // sync pattern at the start of the header
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // reset value of the max length register
    localparam logic [15:0] MAX_LENGTH_RST = 16'hFFFF;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_BAD_SYNC = 2'd2;

    // one received byte
    typedef struct packed {
        logic       start_of_frame;
        logic [7:0] rx_byte;
    } t_sfd_in;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [15:0] copied_count;
    } t_sfd_out;

endpackage

>>> rtl/core/spi_frame_deframer_top.sv
// SPI receive deframer: one received byte per item, flagged when it is the first after chip
// select. Each frame carries a header (0xAA 0x55, then a little-endian length) followed by
// the payload padded to a multiple of 4; up to min(length, max_length) payload bytes come
// out, one result per byte, and the last wire byte of the frame closes it (a bad sync closes
// at header end). The block takes one byte every cycle when the output is not stalled:
// each byte passes from an input register through one decode step into a result register;
// the rate is set by that single-pass decode. max_length is written through i_cfg_wr_en /
// i_cfg_wr_data and should change only while the block is idle.
module spi_frame_deframer_top
    import sfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  t_sfd_in     i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_sfd_out    o_out_item,
    input  logic        i_out_stall
);

    logic     w_stg_valid;
    t_sfd_in  w_stg_item;
    logic     w_take;
    logic     w_out_ready;
    logic     w_res_valid;
    t_sfd_out w_res;

    // input register
    sfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .o_valid (w_stg_valid),
        .o_item  (w_stg_item),
        .i_take  (w_take)
    );

    // frame decode and state
    sfd_deframe #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_deframe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (w_stg_valid),
        .i_item        (w_stg_item),
        .i_out_ready   (w_out_ready),
        .o_take        (w_take),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // result register
    sfd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_item  (w_res),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

>>> rtl/core/sfd_in_stage.sv
module sfd_in_stage
    import sfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sfd_in i_item,
    output logic    o_stall,
    output logic    o_valid,
    output t_sfd_in o_item,
    input  logic    i_take
);

    logic    r_valid;
    logic    n_valid;
    t_sfd_in r_item;
    logic    w_load;

    // hold while the registered item cannot move on
    assign o_stall = r_valid & ~i_take;
    assign w_load  = i_valid & ~o_stall;
    assign n_valid = w_load | (r_valid & ~i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/sfd_deframe.sv
module sfd_deframe
    import sfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  t_sfd_in     i_item,
    input  logic        i_out_ready,
    output logic        o_take,
    output logic        o_res_valid,
    output t_sfd_out    o_res
);

    localparam int HPW = $clog2(HEADER_BYTES);
    localparam logic [HPW-1:0] HPOS_LAST = HPW'(HEADER_BYTES - 1);

    // control state
    logic [15:0]    r_max_length;
    logic [HPW-1:0] r_hpos;
    logic [HPW-1:0] n_hpos;
    logic           r_in_payload;
    logic           n_in_payload;
    logic           r_frame_active;
    logic           n_frame_active;
    logic           r_sync_ok;
    logic           n_sync_ok;

    // frame data state
    logic [7:0]  r_length_low;
    logic [7:0]  n_length_low;
    logic [15:0] r_plen;
    logic [15:0] n_plen;
    logic [16:0] r_padded;
    logic [16:0] n_padded;
    logic [16:0] r_ppos;
    logic [16:0] n_ppos;

    // per item working values
    logic           w_start;
    logic [7:0]     w_byte;
    logic           w_active;
    logic           w_in_payload;
    logic [HPW-1:0] w_hpos;
    logic           w_sync;
    logic [16:0]    w_pad_calc;
    logic [15:0]    w_copy_len;
    logic [16:0]    w_ppos_inc;
    logic           w_last;
    logic           w_has_res;
    t_sfd_out       w_res;

    assign o_take  = i_valid & i_out_ready;
    assign w_start = i_item.start_of_frame;
    assign w_byte  = i_item.rx_byte;

    // a start flag opens a fresh frame
    assign w_active     = w_start | r_frame_active;
    assign w_in_payload = w_start ? 1'b0 : r_in_payload;
    assign w_hpos       = w_start ? '0 : r_hpos;
    assign w_sync       = w_start ? 1'b1 : r_sync_ok;

    assign w_copy_len = (r_plen < r_max_length) ? r_plen : r_max_length;
    assign w_ppos_inc = r_ppos + 17'd1;
    assign w_last     = (w_ppos_inc == r_padded);

    // next state and result for one item
    always_comb begin
        n_hpos         = r_hpos;
        n_in_payload   = r_in_payload;
        n_frame_active = r_frame_active;
        n_sync_ok      = r_sync_ok;
        n_length_low   = r_length_low;
        n_plen         = r_plen;
        n_padded       = r_padded;
        n_ppos         = r_ppos;
        w_pad_calc     = '0;
        w_has_res      = 1'b0;
        w_res          = '0;

        if (w_start) begin
            n_frame_active = 1'b1;
            n_in_payload   = 1'b0;
            n_hpos         = '0;
            n_sync_ok      = 1'b1;
        end

        if (w_active && !w_in_payload) begin
            // header byte
            if (w_hpos == HPW'(0)) begin
                n_sync_ok = (w_byte == SYNC_FIRST);
            end else if (w_hpos == HPW'(1)) begin
                n_sync_ok = w_sync & (w_byte == SYNC_SECOND);
            end else if (w_hpos == HPW'(2)) begin
                n_length_low = w_byte;
            end else if (w_hpos == HPW'(3)) begin
                n_plen = {w_byte, r_length_low};
            end

            w_pad_calc = ({1'b0, n_plen} + 17'd3) & ~17'd3;

            if (w_hpos != HPOS_LAST) begin
                n_hpos = w_hpos + HPW'(1);
            end else if (!n_sync_ok) begin
                // header done, bad sync
                n_frame_active   = 1'b0;
                n_in_payload     = 1'b0;
                n_hpos           = '0;
                w_has_res        = 1'b1;
                w_res.kind       = KIND_BAD_SYNC;
                w_res.frame_end  = 1'b1;
            end else begin
                n_padded = w_pad_calc;
                n_ppos   = '0;
                if (w_pad_calc == 17'd0) begin
                    // empty frame closes on the header
                    n_frame_active  = 1'b0;
                    n_in_payload    = 1'b0;
                    n_hpos          = '0;
                    w_has_res       = 1'b1;
                    w_res.kind      = KIND_END;
                    w_res.frame_end = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                end
            end
        end else if (w_active) begin
            // payload byte
            if (r_ppos < {1'b0, w_copy_len}) begin
                w_has_res          = 1'b1;
                w_res.kind         = KIND_PAYLOAD;
                w_res.data_byte    = w_byte;
                w_res.frame_end    = w_last;
                w_res.copied_count = w_ppos_inc[15:0];
            end else if (w_last) begin
                w_has_res          = 1'b1;
                w_res.kind         = KIND_END;
                w_res.frame_end    = 1'b1;
                w_res.copied_count = w_copy_len;
            end
            n_ppos = w_ppos_inc;
            if (w_last) begin
                n_frame_active = 1'b0;
                n_in_payload   = 1'b0;
                n_hpos         = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length   <= MAX_LENGTH_RST;
            r_hpos         <= '0;
            r_in_payload   <= 1'b0;
            r_frame_active <= 1'b0;
            r_sync_ok      <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_length <= i_cfg_wr_data;
            end
            if (o_take) begin
                r_hpos         <= n_hpos;
                r_in_payload   <= n_in_payload;
                r_frame_active <= n_frame_active;
                r_sync_ok      <= n_sync_ok;
            end
        end
    end

    // frame data registers
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_length_low <= n_length_low;
            r_plen       <= n_plen;
            r_padded     <= n_padded;
            r_ppos       <= n_ppos;
        end
    end

    assign o_res_valid = o_take & w_has_res;
    assign o_res       = w_res;

    // payload phase only inside an open frame
    a_payload_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_frame_active)
        else $error("payload phase outside a frame");

    // payload position stays below the padded length
    a_ppos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_ppos < r_padded))
        else $error("payload position beyond padded length");

    // bad sync always closes with a zero count
    a_bad_sync_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_BAD_SYNC)
            |-> (o_res.frame_end && o_res.copied_count == 16'd0
                 && !n_frame_active))
        else $error("bad sync result malformed");

    // every frame close leaves the header counter cleared
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.frame_end) |=> (r_hpos == '0 && !r_in_payload))
        else $error("frame close did not clear state");

endmodule

>>> rtl/core/sfd_out_stage.sv
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_sfd_out i_item,
    output logic     o_ready,
    output logic     o_valid,
    output t_sfd_out o_item,
    input  logic     i_stall
);

    logic     r_valid;
    logic     n_valid;
    t_sfd_out r_item;

    // free when empty or the held item leaves this cycle
    assign o_ready = ~r_valid | ~i_stall;
    assign n_valid = i_load | (r_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result register, loaded only when free
    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> tb/sv/sfd_checker.sv
`timescale 1ns / 1ps

module sfd_checker
    import sfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  t_sfd_in     i_in_item,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  t_sfd_out    i_out_item,
    input  logic        i_out_stall,
    output int          o_fail_count,
    output int          o_pending
);

    // deframer state as the predictor sees it
    logic [15:0] max_len;
    logic [3:0]  hdr_pos;
    logic        in_payload;
    logic        frame_open;
    logic        sync_good;
    logic [7:0]  len_low;
    logic [15:0] pay_len;
    logic [16:0] padded_len;
    logic [16:0] pay_pos;

    // results still owed by the block, oldest first
    t_sfd_out deframed_q[$];
    int       mismatch_count = 0;
    int       result_num = 0;

    assign o_fail_count = mismatch_count;

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("error at %0t ns: result %0d: %s", $time, result_num, msg);
        mismatch_count++;
    endtask

    task automatic owe_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic fin, input logic [15:0] count);
        deframed_q.push_back('{kind, data, fin, count});
    endtask

    task automatic end_frame();
        frame_open = 1'b0;
        in_payload = 1'b0;
        hdr_pos    = '0;
    endtask

    // advance the frame state by one received byte
    task automatic deframe_byte(input t_sfd_in item);
        logic [15:0] copy_len;
        logic        last;
        if (item.start_of_frame) begin
            frame_open = 1'b1;
            in_payload = 1'b0;
            hdr_pos    = '0;
            sync_good  = 1'b1;
        end
        if (!frame_open) return;

        // header collection
        if (!in_payload) begin
            case (hdr_pos)
                4'd0: sync_good = (item.rx_byte == SYNC_FIRST);
                4'd1: sync_good = sync_good && (item.rx_byte == SYNC_SECOND);
                4'd2: len_low = item.rx_byte;
                4'd3: pay_len = {item.rx_byte, len_low};
                default: ;
            endcase
            if (int'(hdr_pos) + 1 < HEADER_BYTES) begin
                hdr_pos++;
                return;
            end
            if (!sync_good) begin
                end_frame();
                owe_result(KIND_BAD_SYNC, 8'd0, 1'b1, 16'd0);
                return;
            end
            // 17 bits so that 65535 rounds to 65536
            padded_len = ({1'b0, pay_len} + 17'd3) & ~17'd3;
            pay_pos    = '0;
            if (padded_len == '0) begin
                end_frame();
                owe_result(KIND_END, 8'd0, 1'b1, 16'd0);
                return;
            end
            in_payload = 1'b1;
            return;
        end

        // payload, padding and excess bytes
        copy_len = (pay_len < max_len) ? pay_len : max_len;
        last     = ((pay_pos + 17'd1) == padded_len);
        if (pay_pos < {1'b0, copy_len}) begin
            owe_result(KIND_PAYLOAD, item.rx_byte, last, pay_pos[15:0] + 16'd1);
        end else if (last) begin
            owe_result(KIND_END, 8'd0, 1'b1, copy_len);
        end
        pay_pos = pay_pos + 17'd1;
        if (last) end_frame();
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin : monitor
        t_sfd_out want;
        if (!i_rst_n) begin
            max_len    = MAX_LENGTH_RST;
            hdr_pos    = '0;
            in_payload = 1'b0;
            frame_open = 1'b0;
            sync_good  = 1'b1;
            len_low    = '0;
            pay_len    = '0;
            padded_len = '0;
            pay_pos    = '0;
            deframed_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_num++;
                if (deframed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", i_out_item));
                end else begin
                    want = deframed_q.pop_front();
                    if (i_out_item.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  i_out_item.kind, want.kind));
                    if (i_out_item.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %0h, want %0h",
                                                  i_out_item.data_byte, want.data_byte));
                    if (i_out_item.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %0b, want %0b",
                                                  i_out_item.frame_end, want.frame_end));
                    if (i_out_item.copied_count !== want.copied_count)
                        report_mismatch($sformatf("copied_count %0d, want %0d",
                                                  i_out_item.copied_count, want.copied_count));
                end
            end
            if (i_in_valid && !i_in_stall) deframe_byte(i_in_item);
            if (i_cfg_wr_en) max_len = i_cfg_wr_data;
        end
        o_pending <= deframed_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfd_pkg::*;

    localparam int HDR_LEN       = HEADER_BYTES_DEF;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    // slowest correct run is about 1000 bytes plus the long hold
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_in_valid;
    t_sfd_in     i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_sfd_out    o_out_item;
    logic        i_out_stall;

    int          fail_count;
    int          results_pending;
    int          hold_requests = 0;
    bit          in_gaps_on = 1'b0;
    bit          rx_stall_on = 1'b0;
    int          random_bytes = 0;
    int unsigned cycle_count = 0;

    spi_frame_deframer_top #(
        .HEADER_BYTES(HDR_LEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

    sfd_checker #(
        .HEADER_BYTES(HDR_LEN)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_item   (o_out_item),
        .i_out_stall  (i_out_stall),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, a long hold on request
    initial begin : receiver
        int served;
        int pick;
        served = 0;
        forever begin
            if (hold_requests != served) begin
                served++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!rx_stall_on) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                i_out_stall <= (pick >= 65);
                if (pick < 65) repeat ($urandom_range(1, 6)) @(posedge i_clk);
                else if (pick < 95) repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else repeat ($urandom_range(8, 40)) @(posedge i_clk);
            end
        end
    end

    // offer one byte, with an optional gap first, and wait until it is taken
    task automatic send_byte(input logic sof, input logic [7:0] data);
        int gap;
        int pick;
        gap = 0;
        if (in_gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95) gap = $urandom_range(5, 40);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{start_of_frame: sof, rx_byte: data};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic int frame_bytes(input logic [15:0] len);
        return HDR_LEN + ((int'(len) + 3) & ~3);
    endfunction

    // first wire_len bytes of a frame; header tail and payload are random
    task automatic send_frame(input logic [7:0] s0, input logic [7:0] s1,
                              input logic [15:0] len, input int wire_len);
        logic [7:0] data;
        for (int i = 0; i < wire_len; i++) begin
            case (i)
                0: data = s0;
                1: data = s1;
                2: data = len[7:0];
                3: data = len[15:8];
                default: data = 8'($urandom);
            endcase
            send_byte(i == 0, data);
        end
    endtask

    // mostly well-formed frames, some with bad sync, cut short or huge
    task automatic send_random_frame();
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [15:0] len;
        int          pick;
        int          wire_len;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
        end
        s0 = SYNC_FIRST;
        s1 = SYNC_SECOND;
        pick = $urandom_range(0, 99);
        if (pick < 5) s0 = 8'($urandom);
        else if (pick < 10) s1 = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6) len = 16'd0;
        else if (pick < 80) len = 16'($urandom_range(1, 24));
        else if (pick < 92) len = 16'($urandom_range(25, 150));
        else len = 16'($urandom);
        wire_len = frame_bytes(len);
        if (pick >= 92) begin
            wire_len = $urandom_range(1, HDR_LEN + 40);
        end else if (wire_len > 1 && $urandom_range(0, 99) < 8) begin
            wire_len = $urandom_range(1, wire_len - 1);
        end
        // past a bad header the frame is closed, so stop there
        if ((s0 != SYNC_FIRST || s1 != SYNC_SECOND) && wire_len > HDR_LEN) begin
            wire_len = HDR_LEN;
        end
        send_frame(s0, s1, len, wire_len);
        random_bytes += wire_len;
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = random_bytes + n;
        while (random_bytes < stop_at) begin
            if ($urandom_range(0, 9) == 0) in_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) rx_stall_on = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
    endtask

    // stop sending and let every owed result drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_length(input logic [15:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        logic [15:0] max_settings[7];
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames, register at its reset value
        send_byte(1'b0, 8'h3C);                                     // no frame open
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd0, frame_bytes(16'd0));
        send_frame(8'h00, SYNC_SECOND, 16'd4, HDR_LEN + 2);         // bad first sync
        send_frame(SYNC_FIRST, 8'hFF, 16'd4, HDR_LEN);              // bad second sync
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd5, frame_bytes(16'd5));
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd4, frame_bytes(16'd4));
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd12, HDR_LEN + 5);   // restart in payload
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd3, 3);              // restart in header
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'hFFFF, HDR_LEN + 6);
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd1, frame_bytes(16'd1));

        // random frames under a range of max length settings
        in_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        max_settings = '{16'd0, 16'd1, 16'd3, 16'd7, 16'($urandom_range(8, 120)),
                         16'($urandom_range(121, 65534)), MAX_LENGTH_RST};
        foreach (max_settings[k]) begin
            set_max_length(max_settings[k]);
            run_random(90);
        end

        // receiver holds off while a long frame is offered
        wait_idle();
        hold_requests++;
        in_gaps_on = 1'b1;
        send_frame(SYNC_FIRST, SYNC_SECOND, 16'd60, frame_bytes(16'd60));

        wait_idle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
